// ----- src/spmv_pkg.sv -----
`default_nettype none

package spmv_pkg;

    localparam int OP_W        = 2;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 10;
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 64;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int IDX_EXT_W   = 17;

    localparam logic [OP_W-1:0] OP_LOAD_X     = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_ROW   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic             wr;
        logic [ROW_W-1:0] row;
        logic [SUM_W-1:0] sum;
        logic             mark;
    } y_wr_t;

    typedef struct packed {
        logic             status;
        logic [ROW_W-1:0] row_echo;
        logic [SUM_W-1:0] row_sum;
        logic             saturated;
    } result_t;

endpackage

`default_nettype wire

// ----- src/sparse_matrix_vector_multiply_top.sv -----
// Channel   Handshake                   Payload
// item      item_valid / item_ready     operation, row_index, column_index, value
// result    result_valid / result_ready status, row_echo, row_sum, saturated
// config    cfg_write_enable            cfg_index, cfg_data
//
// One item per cycle while no result is held; an item passes the s1, s2 and output
// registers to result_valid. The x memory is written when a load item is taken, and the
// y memory at the edge that loads the result register; two history registers forward
// those writes. After reset a pass clears the y memory, one row per cycle, and
// item_ready stays low until it finishes.
// A held result stalls the whole pipeline, and the input with it.
`default_nettype none

module sparse_matrix_vector_multiply_top #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_enable,
    input  wire logic [spmv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [spmv_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire logic [spmv_pkg::OP_W-1:0]           operation,
    input  wire logic [spmv_pkg::ROW_W-1:0]          row_index,
    input  wire logic [spmv_pkg::COL_W-1:0]          column_index,
    input  wire logic signed [spmv_pkg::VALUE_W-1:0] value,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic                                     status,
    output logic [spmv_pkg::ROW_W-1:0]               row_echo,
    output logic signed [spmv_pkg::SUM_W-1:0]        row_sum,
    output logic                                     saturated
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLUMNS);
    localparam int YW  = spmv_pkg::SUM_W + 1;

    logic [spmv_pkg::CFG_W-1:0] rows_in_use_reg;
    logic [spmv_pkg::CFG_W-1:0] columns_in_use_reg;

    logic           clearing_reg;
    logic [RAW-1:0] clr_cnt_reg;

    logic adv;
    logic accept;
    logic row_ok;
    logic col_ok;
    logic item_ok;

    logic [spmv_pkg::IDX_EXT_W-1:0] row_ext;
    logic [spmv_pkg::IDX_EXT_W-1:0] col_ext;
    logic [spmv_pkg::IDX_EXT_W-1:0] s2_row_ext;

    logic                                s1_valid_reg;
    logic [spmv_pkg::OP_W-1:0]           s1_op_reg;
    logic [spmv_pkg::ROW_W-1:0]          s1_row_reg;
    logic                                s1_ok_reg;
    logic signed [spmv_pkg::VALUE_W-1:0] s1_value_reg;

    logic [spmv_pkg::VALUE_W-1:0] x_rdata;
    logic [YW-1:0]                y_rdata;
    logic signed [spmv_pkg::SUM_W-1:0] product_next;

    logic                       s2_valid_reg;
    logic [spmv_pkg::OP_W-1:0]  s2_op_reg;
    logic [spmv_pkg::ROW_W-1:0] s2_row_reg;
    logic                       s2_ok_reg;
    logic [spmv_pkg::SUM_W-1:0] s2_prod_reg;
    logic [spmv_pkg::SUM_W-1:0] s2_ysum_reg;
    logic                       s2_ymark_reg;

    spmv_pkg::y_wr_t   hist_new_reg;
    spmv_pkg::y_wr_t   hist_old_reg;
    spmv_pkg::y_wr_t   y_write;
    spmv_pkg::y_wr_t   y_write_masked;
    spmv_pkg::result_t acc_result;
    spmv_pkg::result_t out_reg;
    logic              out_valid_reg;

    logic           y_we;
    logic [RAW-1:0] y_waddr;
    logic [YW-1:0]  y_wdata;

    assign adv        = !out_valid_reg || result_ready;
    assign item_ready = adv && !clearing_reg;
    assign accept     = item_valid && item_ready;

    assign row_ext    = spmv_pkg::IDX_EXT_W'(row_index);
    assign col_ext    = spmv_pkg::IDX_EXT_W'(column_index);
    assign s2_row_ext = spmv_pkg::IDX_EXT_W'(s2_row_reg);

    assign row_ok = ({1'b0, row_index} < rows_in_use_reg)
                 && (row_ext < spmv_pkg::IDX_EXT_W'(MAX_ROWS));
    assign col_ok = ({1'b0, column_index} < columns_in_use_reg)
                 && (col_ext < spmv_pkg::IDX_EXT_W'(MAX_COLUMNS));

    always_comb
    begin
        case (operation)
            spmv_pkg::OP_LOAD_X:     item_ok = col_ok;
            spmv_pkg::OP_ACCUMULATE: item_ok = row_ok && col_ok;
            spmv_pkg::OP_READ_ROW:   item_ok = row_ok;
            default:                 item_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg    <= spmv_pkg::CFG_RESET;
            columns_in_use_reg <= spmv_pkg::CFG_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                spmv_pkg::REG_ROWS_IN_USE:    rows_in_use_reg    <= cfg_data;
                spmv_pkg::REG_COLUMNS_IN_USE: columns_in_use_reg <= cfg_data;
                default:                      rows_in_use_reg    <= rows_in_use_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + RAW'(1);
            if (clr_cnt_reg == RAW'(MAX_ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    spmv_ram #(
        .WIDTH (spmv_pkg::VALUE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_x_ram (
        .clk   (clk),
        .we    (accept && operation == spmv_pkg::OP_LOAD_X && col_ok),
        .waddr (col_ext[CAW-1:0]),
        .wdata (value),
        .re    (adv),
        .raddr (col_ext[CAW-1:0]),
        .rdata (x_rdata)
    );

    assign y_write_masked = s2_valid_reg ? y_write : '0;
    assign y_we    = clearing_reg || (adv && y_write_masked.wr);
    assign y_waddr = clearing_reg ? clr_cnt_reg : s2_row_ext[RAW-1:0];
    assign y_wdata = clearing_reg ? '0 : {y_write.sum, y_write.mark};

    spmv_ram #(
        .WIDTH (YW),
        .DEPTH (MAX_ROWS)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (adv),
        .raddr (row_ext[RAW-1:0]),
        .rdata (y_rdata)
    );

    assign product_next = s1_value_reg * $signed(x_rdata);

    spmv_acc u_acc (
        .operation   (s2_op_reg),
        .row         (s2_row_reg),
        .item_ok     (s2_ok_reg),
        .product     (s2_prod_reg),
        .stored_sum  (s2_ysum_reg),
        .stored_mark (s2_ymark_reg),
        .hist_new    (hist_new_reg),
        .hist_old    (hist_old_reg),
        .result      (acc_result),
        .y_write     (y_write)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_new_reg  <= '0;
            hist_old_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            hist_new_reg  <= y_write_masked;
            hist_old_reg  <= hist_new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= operation;
            s1_row_reg   <= row_index;
            s1_ok_reg    <= item_ok;
            s1_value_reg <= value;
            s2_op_reg    <= s1_op_reg;
            s2_row_reg   <= s1_row_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_prod_reg  <= product_next;
            s2_ysum_reg  <= y_rdata[YW-1:1];
            s2_ymark_reg <= y_rdata[0];
            out_reg      <= acc_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign row_echo     = out_reg.row_echo;
    assign row_sum      = out_reg.row_sum;
    assign saturated    = out_reg.saturated;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !item_ready && !s1_valid_reg && !s2_valid_reg)
        else $error("item in flight while the y memory is being cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("clearing pass restarted without a reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == spmv_pkg::STATUS_IGNORED |-> row_sum == '0 && !saturated)
        else $error("ignored item carries a sum or a saturation mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        adv && y_write_masked.wr |=> hist_new_reg.wr)
        else $error("y write leaving the accumulate stage was not recorded");
`endif

endmodule

`default_nettype wire

// ----- src/spmv_ram.sv -----
`default_nettype none

module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/spmv_acc.sv -----
`default_nettype none

// Picks the freshest copy of the row (the two writes still in flight win over
// the memory), then applies the saturating accumulate or the read-and-clear.
module spmv_acc (
    input  wire logic [spmv_pkg::OP_W-1:0]  operation,
    input  wire logic [spmv_pkg::ROW_W-1:0] row,
    input  wire logic                       item_ok,
    input  wire logic [spmv_pkg::SUM_W-1:0] product,
    input  wire logic [spmv_pkg::SUM_W-1:0] stored_sum,
    input  wire logic                       stored_mark,
    input  wire spmv_pkg::y_wr_t            hist_new,
    input  wire spmv_pkg::y_wr_t            hist_old,
    output spmv_pkg::result_t               result,
    output spmv_pkg::y_wr_t                 y_write
);

    logic [spmv_pkg::SUM_W-1:0] cur_sum;
    logic                       cur_mark;
    logic [spmv_pkg::SUM_W:0]   wide_sum;
    logic                       over;
    logic [spmv_pkg::SUM_W-1:0] clamped;

    always_comb
    begin
        if (hist_new.wr && hist_new.row == row)
        begin
            cur_sum  = hist_new.sum;
            cur_mark = hist_new.mark;
        end
        else if (hist_old.wr && hist_old.row == row)
        begin
            cur_sum  = hist_old.sum;
            cur_mark = hist_old.mark;
        end
        else
        begin
            cur_sum  = stored_sum;
            cur_mark = stored_mark;
        end
    end

    assign wide_sum = {cur_sum[spmv_pkg::SUM_W-1], cur_sum}
                    + {product[spmv_pkg::SUM_W-1], product};
    assign over     = wide_sum[spmv_pkg::SUM_W] != wide_sum[spmv_pkg::SUM_W-1];

    always_comb
    begin
        if (!over)
        begin
            clamped = wide_sum[spmv_pkg::SUM_W-1:0];
        end
        else if (wide_sum[spmv_pkg::SUM_W])
        begin
            clamped = spmv_pkg::SUM_MIN;
        end
        else
        begin
            clamped = spmv_pkg::SUM_MAX;
        end
    end

    always_comb
    begin
        result.status    = item_ok ? spmv_pkg::STATUS_DONE : spmv_pkg::STATUS_IGNORED;
        result.row_echo  = row;
        result.row_sum   = '0;
        result.saturated = 1'b0;
        y_write.wr       = 1'b0;
        y_write.row      = row;
        y_write.sum      = '0;
        y_write.mark     = 1'b0;
        if (item_ok)
        begin
            case (operation)
                spmv_pkg::OP_ACCUMULATE:
                begin
                    y_write.wr       = 1'b1;
                    y_write.sum      = clamped;
                    y_write.mark     = cur_mark | over;
                    result.saturated = cur_mark | over;
                end
                spmv_pkg::OP_READ_ROW:
                begin
                    y_write.wr       = 1'b1;
                    result.row_sum   = cur_sum;
                    result.saturated = cur_mark;
                end
                default:
                begin
                    y_write.wr = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_sparse_matrix_vector_multiply_top.sv -----
`default_nettype none

module tb_sparse_matrix_vector_multiply_top;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam logic [spmv_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [spmv_pkg::OP_W-1:0]           op;
        logic [spmv_pkg::ROW_W-1:0]          row;
        logic [spmv_pkg::COL_W-1:0]          col;
        logic signed [spmv_pkg::VALUE_W-1:0] val;
    } item_t;

    typedef enum logic {STEP_ITEM, STEP_CONFIG} step_kind_t;

    typedef struct {
        step_kind_t                       kind;
        item_t                            item;
        bit                               typed;
        spmv_pkg::result_t                result;
        logic [spmv_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [spmv_pkg::CFG_W-1:0]       reg_value;
    } directed_step_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_enable;
    logic [spmv_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [spmv_pkg::CFG_W-1:0]          cfg_data;
    logic                                item_valid;
    logic                                item_ready;
    logic [spmv_pkg::OP_W-1:0]           operation;
    logic [spmv_pkg::ROW_W-1:0]          row_index;
    logic [spmv_pkg::COL_W-1:0]          column_index;
    logic signed [spmv_pkg::VALUE_W-1:0] value;
    logic                                result_valid;
    logic                                result_ready;
    logic                                status;
    logic [spmv_pkg::ROW_W-1:0]          row_echo;
    logic signed [spmv_pkg::SUM_W-1:0]   row_sum;
    logic                                saturated;

    logic signed [spmv_pkg::VALUE_W-1:0] x_vector [MAX_COLUMNS];
    bit                                  x_loaded [MAX_COLUMNS];
    int unsigned                         loaded_columns [$];
    longint                              y_sums [MAX_ROWS];
    bit                                  y_marks [MAX_ROWS];
    int unsigned                         rows_cfg = spmv_pkg::CFG_RESET;
    int unsigned                         cols_cfg = spmv_pkg::CFG_RESET;

    spmv_pkg::result_t                   awaited_results [$];
    directed_step_t                      directed_rows [$];
    spmv_pkg::result_t                   head;
    int unsigned                         mismatches = 0;
    int unsigned                         idle_cycles = 0;
    bit                                  calm;
    bit                                  hold_receiver;
    bit                                  hold_served = 1'b0;
    int unsigned                         phase_rows [6] = '{2047, 16, 1, 1024, 0, 3};
    int unsigned                         phase_cols [6] = '{2047, 8, 1024, 1, 0, 2047};

    sparse_matrix_vector_multiply_top #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .operation        (operation),
        .row_index        (row_index),
        .column_index     (column_index),
        .value            (value),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .status           (status),
        .row_echo         (row_echo),
        .row_sum          (row_sum),
        .saturated        (saturated)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned row_limit();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    endfunction

    function automatic int unsigned column_limit();
        return (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : cols_cfg;
    endfunction

    function automatic spmv_pkg::result_t apply_coo_item(item_t it);
        spmv_pkg::result_t res;
        longint            prod;
        longint            acc;
        longint            total;
        bit                row_ok;
        bit                col_ok;
        row_ok = it.row < row_limit();
        col_ok = it.col < column_limit();
        res.status    = spmv_pkg::STATUS_IGNORED;
        res.row_echo  = it.row;
        res.row_sum   = '0;
        res.saturated = 1'b0;
        case (it.op)
            spmv_pkg::OP_LOAD_X:
                if (col_ok)
                begin
                    x_vector[it.col] = it.val;
                    if (!x_loaded[it.col])
                        loaded_columns.insert(loaded_columns.size(), it.col);
                    x_loaded[it.col] = 1'b1;
                    res.status = spmv_pkg::STATUS_DONE;
                end
            spmv_pkg::OP_ACCUMULATE:
                if (row_ok && col_ok)
                begin
                    prod  = longint'($signed(it.val)) * longint'($signed(x_vector[it.col]));
                    acc   = y_sums[it.row];
                    total = acc + prod;
                    if (acc[63] == prod[63] && total[63] != acc[63])
                    begin
                        total = acc[63] ? spmv_pkg::SUM_MIN : spmv_pkg::SUM_MAX;
                        y_marks[it.row] = 1'b1;
                    end
                    y_sums[it.row] = total;
                    res.saturated  = y_marks[it.row];
                    res.status     = spmv_pkg::STATUS_DONE;
                end
            spmv_pkg::OP_READ_ROW:
                if (row_ok)
                begin
                    res.row_sum     = y_sums[it.row];
                    res.saturated   = y_marks[it.row];
                    y_sums[it.row]  = 0;
                    y_marks[it.row] = 1'b0;
                    res.status      = spmv_pkg::STATUS_DONE;
                end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic logic [spmv_pkg::ROW_W-1:0] pick_index(int unsigned lim);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8 || lim == 0)
            return spmv_pkg::ROW_W'($urandom_range(0, 1023));
        else if (roll < 60)
            return spmv_pkg::ROW_W'($urandom_range(0, ((lim < 24) ? lim : 24) - 1));
        else
            return spmv_pkg::ROW_W'($urandom_range(0, lim - 1));
    endfunction

    // In-range accumulations that would read an x element never loaded are moved to a loaded column.
    function automatic item_t random_item();
        item_t       it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            it.op = spmv_pkg::OP_LOAD_X;
        else if (roll < 75)
            it.op = spmv_pkg::OP_ACCUMULATE;
        else if (roll < 94)
            it.op = spmv_pkg::OP_READ_ROW;
        else
            it.op = OP_UNDEFINED;
        it.row = pick_index(row_limit());
        it.col = pick_index(column_limit());
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            case ($urandom_range(0, 3))
                0: it.val = 32'h7FFF_FFFF;
                1: it.val = 32'h8000_0000;
                2: it.val = '0;
                default: it.val = '1;
            endcase
        end
        else if (roll < 50)
            it.val = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
        else
            it.val = $urandom;
        if (it.op == spmv_pkg::OP_ACCUMULATE && it.row < row_limit()
            && it.col < column_limit() && !x_loaded[it.col])
            it.col = spmv_pkg::COL_W'(
                loaded_columns[$urandom_range(0, loaded_columns.size() - 1)]);
        return it;
    endfunction

    function automatic void add_item(logic [spmv_pkg::OP_W-1:0] op, int row, int col,
                                     logic [31:0] val);
        directed_step_t s;
        s.kind   = STEP_ITEM;
        s.item   = '{op: op, row: spmv_pkg::ROW_W'(row), col: spmv_pkg::COL_W'(col),
                     val: val};
        s.typed  = 1'b0;
        s.result = '0;
        directed_rows.insert(directed_rows.size(), s);
    endfunction

    function automatic void add_expected(logic [spmv_pkg::OP_W-1:0] op, int row, int col,
                                         logic [31:0] val, logic st);
        directed_step_t s;
        s.kind   = STEP_ITEM;
        s.item   = '{op: op, row: spmv_pkg::ROW_W'(row), col: spmv_pkg::COL_W'(col),
                     val: val};
        s.typed  = 1'b1;
        s.result = '{status: st, row_echo: spmv_pkg::ROW_W'(row), row_sum: '0,
                     saturated: 1'b0};
        directed_rows.insert(directed_rows.size(), s);
    endfunction

    function automatic void add_cfg(logic [spmv_pkg::CFG_INDEX_W-1:0] idx, int data);
        directed_step_t s;
        s.kind      = STEP_CONFIG;
        s.reg_index = idx;
        s.reg_value = spmv_pkg::CFG_W'(data);
        directed_rows.insert(directed_rows.size(), s);
    endfunction

    task automatic offer(input item_t it, input bit typed,
                         input spmv_pkg::result_t typed_result);
        spmv_pkg::result_t predicted;
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= it.op;
        row_index    <= it.row;
        column_index <= it.col;
        value        <= it.val;
        do @(posedge clk); while (item_ready !== 1'b1);
        predicted = apply_coo_item(it);
        awaited_results.insert(awaited_results.size(), typed ? typed_result : predicted);
    endtask

    task automatic write_register(input logic [spmv_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [spmv_pkg::CFG_W-1:0] data);
        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == spmv_pkg::REG_ROWS_IN_USE)
            rows_cfg = data;
        else
            cols_cfg = data;
    endtask

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver && !hold_served)
            begin
                hold_served = 1'b1;
                result_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            else
                result_ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result arrived with no item outstanding", $time);
            end
            else
            begin
                head = awaited_results.pop_front();
                if (status !== head.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d, actual %0d", $time, head.status, status);
                end
                if (row_echo !== head.row_echo)
                begin
                    mismatches++;
                    $display("%0t: row_echo expected %0d, actual %0d", $time, head.row_echo,
                             row_echo);
                end
                if (row_sum !== head.row_sum)
                begin
                    mismatches++;
                    $display("%0t: row_sum expected %h, actual %h", $time, head.row_sum, row_sum);
                end
                if (saturated !== head.saturated)
                begin
                    mismatches++;
                    $display("%0t: saturated expected %0d, actual %0d", $time, head.saturated,
                             saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("sparse_matrix_vector_multiply_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int phase;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        item_valid       = 1'b0;
        operation        = '0;
        row_index        = '0;
        column_index     = '0;
        value            = '0;
        calm             = 1'b0;
        hold_receiver    = 1'b0;

        add_expected(spmv_pkg::OP_READ_ROW, 0, 0, 32'h0, spmv_pkg::STATUS_DONE);
        add_expected(OP_UNDEFINED, 513, 514, 32'h5A5A_A5A5, spmv_pkg::STATUS_IGNORED);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 0, 32'h7FFF_FFFF, spmv_pkg::STATUS_DONE);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 1023, 32'h8000_0000, spmv_pkg::STATUS_DONE);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 1, 32'h0001_0000, spmv_pkg::STATUS_DONE);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 2, 32'hFFFF_FFFF, spmv_pkg::STATUS_DONE);
        add_item(spmv_pkg::OP_ACCUMULATE, 5, 1, 32'h0002_0000);
        add_item(spmv_pkg::OP_READ_ROW, 5, 0, 32'h0);
        add_item(spmv_pkg::OP_ACCUMULATE, 7, 1023, 32'h8000_0000);
        add_item(spmv_pkg::OP_ACCUMULATE, 7, 1023, 32'h8000_0000);
        add_item(spmv_pkg::OP_ACCUMULATE, 7, 2, 32'h0000_0001);
        add_item(spmv_pkg::OP_READ_ROW, 7, 0, 32'h0);
        add_expected(spmv_pkg::OP_READ_ROW, 7, 0, 32'h0, spmv_pkg::STATUS_DONE);
        add_item(spmv_pkg::OP_ACCUMULATE, 8, 1023, 32'h7FFF_FFFF);
        add_item(spmv_pkg::OP_ACCUMULATE, 8, 1023, 32'h7FFF_FFFF);
        add_item(spmv_pkg::OP_ACCUMULATE, 8, 1023, 32'h7FFF_FFFF);
        add_item(spmv_pkg::OP_READ_ROW, 8, 0, 32'h0);
        add_item(spmv_pkg::OP_ACCUMULATE, 1023, 0, 32'h8000_0000);
        add_cfg(spmv_pkg::REG_ROWS_IN_USE, 8);
        add_cfg(spmv_pkg::REG_COLUMNS_IN_USE, 4);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 4, 32'h1234_5678, spmv_pkg::STATUS_IGNORED);
        add_expected(spmv_pkg::OP_ACCUMULATE, 8, 1, 32'h0001_0000, spmv_pkg::STATUS_IGNORED);
        add_expected(spmv_pkg::OP_READ_ROW, 8, 0, 32'h0, spmv_pkg::STATUS_IGNORED);
        add_item(spmv_pkg::OP_ACCUMULATE, 7, 1, 32'hFFFF_0000);
        add_cfg(spmv_pkg::REG_ROWS_IN_USE, 0);
        add_expected(spmv_pkg::OP_READ_ROW, 0, 0, 32'h0, spmv_pkg::STATUS_IGNORED);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 3, 32'h1234_5678, spmv_pkg::STATUS_DONE);
        add_cfg(spmv_pkg::REG_COLUMNS_IN_USE, 0);
        add_expected(spmv_pkg::OP_LOAD_X, 0, 0, 32'h0000_0001, spmv_pkg::STATUS_IGNORED);
        add_cfg(spmv_pkg::REG_ROWS_IN_USE, 2047);
        add_cfg(spmv_pkg::REG_COLUMNS_IN_USE, 2047);
        add_item(spmv_pkg::OP_READ_ROW, 1023, 0, 32'h0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == STEP_CONFIG)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        end

        // The second phase runs without gaps; the fourth starts with a long receiver stall.
        for (phase = 0; phase < 6; phase++)
        begin
            write_register(spmv_pkg::REG_ROWS_IN_USE,
                           spmv_pkg::CFG_W'(phase == 4 ? $urandom_range(1, 1024)
                                                       : phase_rows[phase]));
            write_register(spmv_pkg::REG_COLUMNS_IN_USE,
                           spmv_pkg::CFG_W'(phase == 4 ? $urandom_range(1, 1024)
                                                       : phase_cols[phase]));
            calm = (phase == 1);
            if (phase == 3)
                hold_receiver = 1'b1;
            repeat (92) offer(random_item(), 1'b0, '0);
        end

        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("sparse_matrix_vector_multiply_top regression: pass");
        else
            $display("sparse_matrix_vector_multiply_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
